[hw/rtl/fsa_pkg.sv]
// shared constants and codes for the fixed block free list allocator
`timescale 1ns / 1ps

package fsa_pkg;

  localparam int ID_W               = 12;
  localparam int CNT_W              = 13;
  localparam int LINK_W             = ID_W + 1;
  localparam int CFG_IDX_W          = 2;
  localparam int ID_LIMIT           = 4096;
  localparam int MAX_BLOCKS_DEFAULT = 4096;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_POOL_ENABLE = 2'd0,
    CFG_BLOCK_COUNT = 2'd1
  } cfg_reg_t;

  localparam logic REQ_ALLOC   = 1'b0;
  localparam logic REQ_RELEASE = 1'b1;

endpackage

[hw/rtl/fsa_ifs.sv]
// request, response and configuration channel interfaces
`timescale 1ns / 1ps

interface fsa_req_if;
  logic                    valid;
  logic                    ready;
  logic                    req_type;
  logic [fsa_pkg::ID_W-1:0] block_id;

  modport source (output valid, output req_type, output block_id, input ready);
  modport sink   (input valid, input req_type, input block_id, output ready);
endinterface

interface fsa_rsp_if;
  logic                    valid;
  logic                    ready;
  logic                    ok;
  logic [fsa_pkg::ID_W-1:0] granted_id;

  modport source (output valid, output ok, output granted_id, input ready);
  modport sink   (input valid, input ok, input granted_id, output ready);
endinterface

interface fsa_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [fsa_pkg::CFG_IDX_W-1:0] index;
  logic [fsa_pkg::CNT_W-1:0]     data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

[hw/rtl/fsa_ram.sv]
// generic single-write, single-read ram with registered read data
`timescale 1ns / 1ps

module fsa_ram #(
  parameter int WIDTH = fsa_pkg::LINK_W,
  parameter int DEPTH = fsa_pkg::MAX_BLOCKS_DEFAULT
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[hw/rtl/fixed_block_free_list_allocator.sv]
// Fixed block free list allocator: hands out and takes back block numbers
// last in, first out. Released blocks form a linked stack kept in a link
// memory of min(MAX_BLOCKS, 4096) entries, sitting on top of a counter of
// never-used blocks, so after a refill blocks come out in ascending order.
// Writing either configuration register refills the pool; there is no
// clearing pass after reset. A configuration write is taken only between
// requests and holds off a waiting request for that cycle. Every request gets
// exactly one response, held in an output register. A release, a failed
// request or an allocate from the fresh counter is done in ST_IDLE; an
// allocate from the released stack also passes through ST_POP, which waits
// for the registered read of the link memory to return the next stack top
// before the following request is taken.
`timescale 1ns / 1ps

module fixed_block_free_list_allocator #(
  parameter int MAX_BLOCKS = fsa_pkg::MAX_BLOCKS_DEFAULT
) (
  input  logic      clk,
  input  logic      rst,
  fsa_req_if.sink   req,
  fsa_rsp_if.source rsp,
  fsa_cfg_if.sink   cfg
);

  import fsa_pkg::*;

  localparam int DEPTH  = (MAX_BLOCKS < ID_LIMIT) ? MAX_BLOCKS : ID_LIMIT;
  localparam int ADDR_W = $clog2(DEPTH);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_POP  = 2'b10
  } state_t;

  state_t             state;
  logic               pool_enable;
  logic [CNT_W-1:0]   block_count;
  logic [ID_W-1:0]    released_top;
  logic               released_nonempty;
  logic [CNT_W-1:0]   fresh_next;
  logic               rsp_valid;
  logic               rsp_ok;
  logic [ID_W-1:0]    rsp_granted;

  logic [CNT_W-1:0]   count;
  logic               req_fire;
  logic               cfg_hit;
  logic               is_alloc;
  logic               pop_hit;
  logic               fresh_hit;
  logic               rel_hit;
  logic               mem_we;
  logic               mem_re;
  logic [ADDR_W-1:0]  mem_waddr;
  logic [ADDR_W-1:0]  mem_raddr;
  logic [LINK_W-1:0]  mem_wdata;
  logic [LINK_W-1:0]  mem_rdata;

  assign req.ready     = (state == ST_IDLE) && !cfg.valid && (!rsp_valid || rsp.ready);
  assign cfg.ready     = (state == ST_IDLE);
  assign rsp.valid     = rsp_valid;
  assign rsp.ok        = rsp_ok;
  assign rsp.granted_id = rsp_granted;

  always_comb begin
    count     = (block_count > CNT_W'(DEPTH)) ? CNT_W'(DEPTH) : block_count;
    req_fire  = req.valid && req.ready;
    cfg_hit   = cfg.valid && cfg.ready &&
                (cfg.index == CFG_POOL_ENABLE || cfg.index == CFG_BLOCK_COUNT);
    is_alloc  = (req.req_type == REQ_ALLOC);
    pop_hit   = pool_enable && is_alloc && released_nonempty;
    fresh_hit = pool_enable && is_alloc && !released_nonempty && (fresh_next < count);
    rel_hit   = pool_enable && !is_alloc && ({1'b0, req.block_id} < count);
    mem_we    = req_fire && rel_hit;
    mem_waddr = req.block_id[ADDR_W-1:0];
    mem_wdata = {released_nonempty, released_top};
    mem_re    = req_fire && pop_hit;
    mem_raddr = released_top[ADDR_W-1:0];
  end

  fsa_ram #(
    .WIDTH (LINK_W),
    .DEPTH (DEPTH)
  ) u_link_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state             <= ST_IDLE;
      pool_enable       <= 1'b0;
      block_count       <= '0;
      released_top      <= '0;
      released_nonempty <= 1'b0;
      fresh_next        <= '0;
      rsp_valid         <= 1'b0;
    end else begin
      if (req_fire) begin
        rsp_valid <= 1'b1;
      end else if (rsp.valid && rsp.ready) begin
        rsp_valid <= 1'b0;
      end
      if (cfg_hit) begin
        unique case (cfg.index)
          CFG_POOL_ENABLE: pool_enable <= cfg.data[0];
          CFG_BLOCK_COUNT: block_count <= cfg.data;
          default: begin
          end
        endcase
        // refill
        released_top      <= '0;
        released_nonempty <= 1'b0;
        fresh_next        <= '0;
      end else begin
        unique case (state)
          ST_IDLE: begin
            if (req_fire) begin
              if (pop_hit) begin
                state <= ST_POP;
              end else if (fresh_hit) begin
                fresh_next <= fresh_next + CNT_W'(1);
              end else if (rel_hit) begin
                released_top      <= req.block_id;
                released_nonempty <= 1'b1;
              end
            end
          end
          ST_POP: begin
            released_top      <= mem_rdata[ID_W-1:0];
            released_nonempty <= mem_rdata[ID_W];
            state             <= ST_IDLE;
          end
          default: begin
            state <= ST_IDLE;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req_fire) begin
      rsp_ok <= pop_hit || fresh_hit || rel_hit;
      if (pop_hit) begin
        rsp_granted <= released_top;
      end else if (fresh_hit) begin
        rsp_granted <= fresh_next[ID_W-1:0];
      end else begin
        rsp_granted <= '0;
      end
    end
  end

endmodule

[hw/rtl/fsa_checker.sv]
// port-level assertions for the allocator, bound to the top level
`timescale 1ns / 1ps

module fsa_checker (
  input logic                     clk,
  input logic                     rst,
  input logic                     req_valid,
  input logic                     req_ready,
  input logic                     rsp_valid,
  input logic                     rsp_ready,
  input logic                     rsp_ok,
  input logic [fsa_pkg::ID_W-1:0] rsp_granted_id
);

  // every accepted request shows a response on the next cycle
  assert property (@(posedge clk) disable iff (rst)
    (req_valid && req_ready) |=> rsp_valid)
    else $error("accepted request produced no response");

  // a request is never taken while a stalled response would be overwritten
  assert property (@(posedge clk) disable iff (rst)
    (req_valid && req_ready) |-> (!rsp_valid || rsp_ready))
    else $error("request accepted over a pending response");

  // failed requests carry a zero block number
  assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && !rsp_ok) |-> (rsp_granted_id == '0))
    else $error("failed response with non-zero block number");

  assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && !rsp_ready) |=>
      (rsp_valid && $stable(rsp_ok) && $stable(rsp_granted_id)))
    else $error("stalled response changed");

endmodule

bind fixed_block_free_list_allocator fsa_checker u_fsa_checker (
  .clk            (clk),
  .rst            (rst),
  .req_valid      (req.valid),
  .req_ready      (req.ready),
  .rsp_valid      (rsp.valid),
  .rsp_ready      (rsp.ready),
  .rsp_ok         (rsp.ok),
  .rsp_granted_id (rsp.granted_id)
);
